// ===== rtl/impq_pkg.sv =====
// Shared types and constants of the indexed max priority queue.
package impq_pkg;

    localparam int CAPACITY  = 256;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int ID_BITS   = 8;
    localparam int ID_COUNT  = 1 << ID_BITS;
    localparam int KEY_BITS  = 32;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INSERT  = 2'd0;
    localparam kind_t KIND_CHANGE  = 2'd1;
    localparam kind_t KIND_EXTRACT = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_EMPTY   = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_ABSENT  = 3'd3;
    localparam status_t ST_PRESENT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_SLOT, S_EXT, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_CMP, S_PLACE, S_RESULT
    } state_t;

    typedef struct packed {
        logic load;       // latch request
        logic rd_root;    // read root on port A and last entry on port B
        logic rd_child;   // read left child on port A and right child on port B
        logic ins_start;  // new entry becomes the moving entry at the last slot
        logic chg_start;  // present entry becomes the moving entry with its new key
        logic ext_start;  // capture root, last entry becomes the moving entry at the root
        logic up_move;    // parent entry moves down into the hole
        logic dn_move;    // larger child entry moves up into the hole
        logic place;      // moving entry is written into the hole
        logic set_status;
        status_t status;
    } impq_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       present;
        logic       full;
        logic       empty;
        logic       at_root;
        logic       up_swap;
        logic       has_left;
        logic       dn_swap;
    } impq_stat_t;

endpackage

// ===== rtl/impq_datapath.sv =====
// Heap stores, request registers and compare logic of the priority queue.
module impq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  impq_pkg::impq_cmd_t           cmd,
    output impq_pkg::impq_stat_t          stat,
    input  logic [1:0]                    in_kind,
    input  logic [7:0]                    in_id,
    input  logic [impq_pkg::KEY_BITS-1:0] in_key,
    output logic [7:0]                    res_id,
    output logic [impq_pkg::KEY_BITS-1:0] res_key,
    output logic [2:0]                    res_status,
    output logic [8:0]                    res_occ
);
    localparam int SB = impq_pkg::SLOT_BITS;
    localparam int CB = impq_pkg::CNT_BITS;
    localparam int KB = impq_pkg::KEY_BITS;

    logic [KB-1:0] key_mem [impq_pkg::CAPACITY];
    logic [7:0]    ida_mem [impq_pkg::CAPACITY];
    logic [SB-1:0] sid_mem [impq_pkg::ID_COUNT];
    logic [impq_pkg::ID_COUNT-1:0] present_reg, present_next;

    logic [1:0]    kind_reg;
    logic [7:0]    id_reg;
    logic [KB-1:0] key_reg;
    logic [CB-1:0] count_reg;
    // The entry being sifted is held here; cur_reg is the slot of the hole it leaves.
    logic [SB-1:0] cur_reg;
    logic [KB-1:0] mkey_reg;
    logic [7:0]    mid_reg;
    logic [7:0]    rid_reg;
    logic [KB-1:0] rkey_reg;
    logic [2:0]    status_reg;
    // Registered read data of the two store ports.
    logic [KB-1:0] rka_reg, rkb_reg;
    logic [7:0]    ria_reg, rib_reg;
    logic [SB-1:0] sid_rd_reg;

    logic [SB-1:0] parent, left_s, right_s, last_s, addr_a, addr_b, dst_s;
    logic [CB:0]   left_w, right_w;
    logic          l_ok, r_ok, l_gt, r_gt_big, wr_en;
    logic [KB-1:0] wr_key;
    logic [7:0]    wr_id;

    always_comb begin
        parent  = SB'((cur_reg - 1'b1) >> 1);
        left_w  = (CB+1)'({cur_reg, 1'b1});
        right_w = (CB+1)'({cur_reg, 1'b0}) + (CB+1)'(2);
        left_s  = left_w[SB-1:0];
        right_s = right_w[SB-1:0];
        last_s  = SB'(count_reg - 1'b1);
        l_ok    = left_w  < (CB+1)'(count_reg);
        r_ok    = right_w < (CB+1)'(count_reg);
        l_gt    = $signed(rka_reg) > $signed(mkey_reg);
        r_gt_big = r_ok && (l_gt ? ($signed(rkb_reg) > $signed(rka_reg))
                                 : ($signed(rkb_reg) > $signed(mkey_reg)));
        addr_a = parent;
        addr_b = right_s;
        if (cmd.rd_root) begin
            addr_a = '0;
            addr_b = last_s;
        end else if (cmd.rd_child) begin
            addr_a = left_s;
        end
        // Entry written into the hole, and the slot the hole moves on to.
        wr_en = cmd.up_move || cmd.dn_move || cmd.place;
        if (cmd.place) begin
            wr_key = mkey_reg;
            wr_id  = mid_reg;
            dst_s  = cur_reg;
        end else if (cmd.dn_move && r_gt_big) begin
            wr_key = rkb_reg;
            wr_id  = rib_reg;
            dst_s  = right_s;
        end else begin
            wr_key = rka_reg;
            wr_id  = ria_reg;
            dst_s  = cmd.dn_move ? left_s : parent;
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.present  = present_reg[id_reg];
    assign stat.full     = count_reg >= CB'(impq_pkg::CAPACITY);
    assign stat.empty    = count_reg == '0;
    assign stat.at_root  = cur_reg == '0;
    assign stat.up_swap  = $signed(rka_reg) < $signed(mkey_reg);
    assign stat.has_left = l_ok;
    assign stat.dn_swap  = l_gt || r_gt_big;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            count_reg   <= '0;
        end else begin
            present_reg <= present_next;
            if (cmd.ins_start) count_reg <= count_reg + 1'b1;
            if (cmd.ext_start) count_reg <= count_reg - 1'b1;
        end
    end

    always_comb begin
        present_next = present_reg;
        if (cmd.ins_start) present_next[id_reg] = 1'b1;
        if (cmd.ext_start) present_next[ria_reg] = 1'b0;
    end

    // Stores: two registered read ports and one write port on the heap slots.
    always_ff @(posedge aclk) begin
        rka_reg    <= key_mem[addr_a];
        rkb_reg    <= key_mem[addr_b];
        ria_reg    <= ida_mem[addr_a];
        rib_reg    <= ida_mem[addr_b];
        sid_rd_reg <= sid_mem[id_reg];
        if (wr_en) begin
            key_mem[cur_reg] <= wr_key;
            ida_mem[cur_reg] <= wr_id;
            sid_mem[wr_id]   <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= in_kind;
            id_reg     <= in_id;
            key_reg    <= in_key;
            rid_reg    <= '0;
            rkey_reg   <= '0;
            status_reg <= impq_pkg::ST_OK;
        end
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.ins_start) begin
            cur_reg  <= count_reg[SB-1:0];
            mkey_reg <= key_reg;
            mid_reg  <= id_reg;
        end
        if (cmd.chg_start) begin
            cur_reg  <= sid_rd_reg;
            mkey_reg <= key_reg;
            mid_reg  <= id_reg;
        end
        if (cmd.ext_start) begin
            rid_reg  <= ria_reg;
            rkey_reg <= rka_reg;
            cur_reg  <= '0;
            mkey_reg <= rkb_reg;
            mid_reg  <= rib_reg;
        end
        if (cmd.up_move || cmd.dn_move) cur_reg <= dst_s;
    end

    assign res_id     = rid_reg;
    assign res_key    = rkey_reg;
    assign res_status = status_reg;
    assign res_occ    = 9'(count_reg);

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CB'(impq_pkg::CAPACITY))
        else $error("entry count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_start |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the heap");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins_start && cmd.ext_start))
        else $error("insert and extract at once");
endmodule

// ===== rtl/impq_ctrl.sv =====
// Sequencing state machine of the priority queue.
module impq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  impq_pkg::impq_stat_t  stat,
    output impq_pkg::impq_cmd_t   cmd
);
    impq_pkg::state_t state_reg, state_next;
    logic chg_reg, chg_next;   // sift up still to be followed by sift down

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= impq_pkg::S_IDLE;
            chg_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            chg_reg   <= chg_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        chg_next   = chg_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            impq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = impq_pkg::S_DECODE;
                end
            end
            impq_pkg::S_DECODE: begin
                cmd.rd_root = 1'b1;
                state_next  = impq_pkg::S_RESULT;
                unique case (stat.kind)
                    impq_pkg::KIND_INSERT: begin
                        if (stat.present) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = impq_pkg::ST_PRESENT;
                        end else if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = impq_pkg::ST_FULL;
                        end else begin
                            cmd.ins_start = 1'b1;
                            chg_next      = 1'b0;
                            state_next    = impq_pkg::S_UP_RD;
                        end
                    end
                    impq_pkg::KIND_CHANGE: begin
                        if (!stat.present) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = impq_pkg::ST_ABSENT;
                        end else begin
                            chg_next   = 1'b1;
                            state_next = impq_pkg::S_RD_SLOT;
                        end
                    end
                    impq_pkg::KIND_EXTRACT: begin
                        if (stat.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = impq_pkg::ST_EMPTY;
                        end else begin
                            state_next = impq_pkg::S_EXT;
                        end
                    end
                    default: ;
                endcase
            end
            impq_pkg::S_RD_SLOT: begin
                cmd.chg_start = 1'b1;
                state_next    = impq_pkg::S_UP_RD;
            end
            impq_pkg::S_EXT: begin
                cmd.ext_start = 1'b1;
                state_next    = impq_pkg::S_DN_RD;
            end
            impq_pkg::S_UP_RD: begin
                if (stat.at_root) begin
                    state_next = chg_reg ? impq_pkg::S_DN_RD : impq_pkg::S_PLACE;
                end else begin
                    state_next = impq_pkg::S_UP_CMP;
                end
            end
            impq_pkg::S_UP_CMP: begin
                if (stat.up_swap) begin
                    cmd.up_move = 1'b1;
                    state_next  = impq_pkg::S_UP_RD;
                end else begin
                    state_next = chg_reg ? impq_pkg::S_DN_RD : impq_pkg::S_PLACE;
                end
            end
            impq_pkg::S_DN_RD: begin
                cmd.rd_child = 1'b1;
                state_next   = stat.has_left ? impq_pkg::S_DN_CMP : impq_pkg::S_PLACE;
            end
            impq_pkg::S_DN_CMP: begin
                if (stat.dn_swap) begin
                    cmd.dn_move = 1'b1;
                    state_next  = impq_pkg::S_DN_RD;
                end else begin
                    state_next = impq_pkg::S_PLACE;
                end
            end
            impq_pkg::S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = impq_pkg::S_RESULT;
            end
            impq_pkg::S_RESULT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = impq_pkg::S_IDLE;
            end
            default: state_next = impq_pkg::S_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.up_move |=> state_reg == impq_pkg::S_UP_RD)
        else $error("sift up did not go on to the parent");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dn_move |=> state_reg == impq_pkg::S_DN_RD)
        else $error("sift down did not go on to the children");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == impq_pkg::S_DECODE)
        else $error("accepted request not decoded");
endmodule

// ===== rtl/indexed_max_priority_queue.sv =====
// Top level of the indexed binary max-heap priority queue.
// After the input transfer, a rejected request or one of the unused kind goes from S_DECODE
// straight to S_RESULT, where m_tvalid is raised; a sift reads and compares per heap level.
// One request is handled at a time: a new request is not taken until the result of the
// last one has been taken.
// Reset (aresetn low, synchronous) empties the heap and clears the id presence bits.
module indexed_max_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: kind [1:0], item_id [9:2], item_key [41:10], zero fill [47:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: out_id [7:0], out_key [39:8], status [42:40], occupancy [51:43], zeros
    output logic [55:0] m_tdata
);
    impq_pkg::impq_cmd_t  cmd;
    impq_pkg::impq_stat_t stat;
    logic [7:0]  res_id;
    logic [31:0] res_key;
    logic [2:0]  res_status;
    logic [8:0]  res_occ;

    impq_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .stat, .cmd
    );

    impq_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_kind(s_tdata[1:0]), .in_id(s_tdata[9:2]), .in_key(s_tdata[41:10]),
        .res_id, .res_key, .res_status, .res_occ
    );

    // The result registers hold still until the transfer is taken.
    assign m_tdata = {4'd0, res_occ, res_status, res_key, res_id};
endmodule
